// ===== sv/vcsl_pkg.sv =====
// shared widths, step counts, register indexes and the planar control bundle
// for the velocity command slew limiter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vcsl_pkg;

    localparam int VEL_W       = 24;               // Q8.16 velocity
    localparam int TIME_W      = 48;               // Q32.16 seconds
    localparam int FRAC_W      = 16;               // fraction bits of time
    localparam int STEP_W      = 26;               // saturated step bound
    localparam int DELTA_W     = VEL_W + 1;        // target minus ramp
    localparam int BOUND_STEPS = DELTA_W;          // serial multiply / square bits
    localparam int ROOT_STEPS  = STEP_W;           // root digits, one pair per cycle
    localparam int DIV_STEPS   = VEL_W;            // quotient bits
    localparam int CNT_W       = $clog2(ROOT_STEPS + 1);
    localparam int CFG_IDX_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LIN_ACCEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_ACCEL = CFG_IDX_W'(1);

    // sequencing strobes for the planar limiter datapath
    typedef struct packed {
        logic load;
        logic sq_step;
        logic root_load;
        logic root_step;
        logic div_load;
        logic div_step;
    } plan_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/vcsl_step_bound.sv =====
// bit-serial step bound: floor(limit * dt / 2^16), saturated to STEP_W bits
// depends on vcsl_pkg
`timescale 1ns / 1ps
`default_nettype none

module vcsl_step_bound (
    input  logic                          aclk,
    input  logic                          load,
    input  logic                          step,
    input  logic [vcsl_pkg::VEL_W-1:0]    limit,
    input  logic [vcsl_pkg::TIME_W-1:0]   dt,
    output logic [vcsl_pkg::STEP_W-1:0]   bound
);

    localparam int ACC_W = vcsl_pkg::STEP_W + vcsl_pkg::FRAC_W;

    logic [vcsl_pkg::BOUND_STEPS-1:0] lim_sh_reg, lim_sh_next;
    logic [ACC_W-1:0]                 acc_reg, acc_next;
    logic                             sat_reg, sat_next;
    logic [ACC_W+1:0]                 sum;
    logic                             msb;
    logic                             dt_big;

    // limit bits enter msb first, accumulator doubles each beat
    always_comb begin
        msb         = lim_sh_reg[vcsl_pkg::BOUND_STEPS-1];
        dt_big      = |dt[vcsl_pkg::TIME_W-1:ACC_W];
        sum         = {1'b0, acc_reg, 1'b0}
                    + (msb ? (ACC_W+2)'(dt[ACC_W-1:0]) : '0);
        lim_sh_next = lim_sh_reg;
        acc_next    = acc_reg;
        sat_next    = sat_reg;
        if (load) begin
            lim_sh_next = vcsl_pkg::BOUND_STEPS'(limit);
            acc_next    = '0;
            sat_next    = 1'b0;
        end else if (step) begin
            lim_sh_next = {lim_sh_reg[vcsl_pkg::BOUND_STEPS-2:0], 1'b0};
            acc_next    = sum[ACC_W-1:0];
            // partial products only grow, so overflow is sticky
            sat_next    = sat_reg | (msb & dt_big) | (|sum[ACC_W+1:ACC_W]);
        end
    end

    always_ff @(posedge aclk) begin
        lim_sh_reg <= lim_sh_next;
        acc_reg    <= acc_next;
        sat_reg    <= sat_next;
    end

    assign bound = sat_reg ? {vcsl_pkg::STEP_W{1'b1}}
                           : acc_reg[ACC_W-1:vcsl_pkg::FRAC_W];

endmodule

`default_nettype wire

// ===== sv/vcsl_planar.sv =====
// planar limiter datapath: serial squares, digit-pair square root, serial
// scaling products and restoring divides; sequenced by the top level, uses vcsl_pkg
`timescale 1ns / 1ps
`default_nettype none

module vcsl_planar (
    input  logic                                aclk,
    input  vcsl_pkg::plan_ctrl_t                ctrl,
    input  logic signed [vcsl_pkg::DELTA_W-1:0] dx,
    input  logic signed [vcsl_pkg::DELTA_W-1:0] dy,
    input  logic [vcsl_pkg::STEP_W-1:0]         bound,
    output logic                                limited,
    output logic signed [vcsl_pkg::DELTA_W-1:0] step_x,
    output logic signed [vcsl_pkg::DELTA_W-1:0] step_y
);

    localparam int MAG_W  = vcsl_pkg::DELTA_W;
    localparam int SQ_W   = 2 * vcsl_pkg::VEL_W + 1;
    localparam int RAD_W  = 2 * vcsl_pkg::ROOT_STEPS;
    localparam int ROOT_W = vcsl_pkg::ROOT_STEPS;
    localparam int REM_W  = ROOT_W + 1;
    localparam int PROD_W = MAG_W + vcsl_pkg::STEP_W;
    localparam int DIVR_W = ROOT_W + vcsl_pkg::DIV_STEPS;
    localparam int Q_W    = vcsl_pkg::DIV_STEPS;

    logic [MAG_W-1:0]  mag_x_reg, mag_y_reg, mag_x_next, mag_y_next;
    logic              neg_x_reg, neg_y_reg, neg_x_next, neg_y_next;
    logic [MAG_W-1:0]  sh_x_reg, sh_y_reg, sh_x_next, sh_y_next;
    logic [SQ_W-1:0]   sq_x_reg, sq_y_reg, sq_x_next, sq_y_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [vcsl_pkg::STEP_W-1:0] dsh_reg, dsh_next;
    logic [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_x_next, prod_y_next;
    logic [DIVR_W-1:0] div_x_reg, div_y_reg, div_x_next, div_y_next;

    logic [REM_W+1:0]  cur, trial, cur_sub;
    logic              root_ge;
    logic [ROOT_W:0]   rx2, ry2, rx_sub, ry_sub, den;
    logic              gx, gy;
    logic [MAG_W-1:0]  qx, qy;

    always_comb begin
        // root digit pair
        cur     = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        root_ge = cur >= trial;
        cur_sub = cur - trial;
        // restoring divide by the root
        den     = {1'b0, root_reg};
        rx2     = {div_x_reg[DIVR_W-1 -: ROOT_W], div_x_reg[Q_W-1]};
        ry2     = {div_y_reg[DIVR_W-1 -: ROOT_W], div_y_reg[Q_W-1]};
        gx      = rx2 >= den;
        gy      = ry2 >= den;
        rx_sub  = rx2 - den;
        ry_sub  = ry2 - den;

        mag_x_next  = mag_x_reg;
        mag_y_next  = mag_y_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        sh_x_next   = sh_x_reg;
        sh_y_next   = sh_y_reg;
        sq_x_next   = sq_x_reg;
        sq_y_next   = sq_y_reg;
        rad_next    = rad_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        dsh_next    = dsh_reg;
        prod_x_next = prod_x_reg;
        prod_y_next = prod_y_reg;
        div_x_next  = div_x_reg;
        div_y_next  = div_y_reg;

        if (ctrl.load) begin
            neg_x_next = dx[MAG_W-1];
            neg_y_next = dy[MAG_W-1];
            mag_x_next = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            mag_y_next = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
            sh_x_next  = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            sh_y_next  = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
            sq_x_next  = '0;
            sq_y_next  = '0;
        end
        if (ctrl.sq_step) begin
            sh_x_next = {sh_x_reg[MAG_W-2:0], 1'b0};
            sh_y_next = {sh_y_reg[MAG_W-2:0], 1'b0};
            sq_x_next = {sq_x_reg[SQ_W-2:0], 1'b0}
                      + (sh_x_reg[MAG_W-1] ? SQ_W'(mag_x_reg) : '0);
            sq_y_next = {sq_y_reg[SQ_W-2:0], 1'b0}
                      + (sh_y_reg[MAG_W-1] ? SQ_W'(mag_y_reg) : '0);
        end
        if (ctrl.root_load) begin
            rad_next    = RAD_W'({1'b0, sq_x_reg} + {1'b0, sq_y_reg});
            rem_next    = '0;
            root_next   = '0;
            dsh_next    = bound;
            prod_x_next = '0;
            prod_y_next = '0;
        end
        if (ctrl.root_step) begin
            rad_next    = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next    = root_ge ? cur_sub[REM_W-1:0] : cur[REM_W-1:0];
            root_next   = {root_reg[ROOT_W-2:0], root_ge};
            dsh_next    = {dsh_reg[vcsl_pkg::STEP_W-2:0], 1'b0};
            prod_x_next = {prod_x_reg[PROD_W-2:0], 1'b0}
                        + (dsh_reg[vcsl_pkg::STEP_W-1] ? PROD_W'(mag_x_reg) : '0);
            prod_y_next = {prod_y_reg[PROD_W-2:0], 1'b0}
                        + (dsh_reg[vcsl_pkg::STEP_W-1] ? PROD_W'(mag_y_reg) : '0);
        end
        // quotient fits Q_W bits, so the top product bit is always clear
        if (ctrl.div_load) begin
            div_x_next = prod_x_reg[DIVR_W-1:0];
            div_y_next = prod_y_reg[DIVR_W-1:0];
        end
        if (ctrl.div_step) begin
            div_x_next = {(gx ? rx_sub[ROOT_W-1:0] : rx2[ROOT_W-1:0]),
                          div_x_reg[Q_W-2:0], gx};
            div_y_next = {(gy ? ry_sub[ROOT_W-1:0] : ry2[ROOT_W-1:0]),
                          div_y_reg[Q_W-2:0], gy};
        end
    end

    always_ff @(posedge aclk) begin
        mag_x_reg  <= mag_x_next;
        mag_y_reg  <= mag_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        sh_x_reg   <= sh_x_next;
        sh_y_reg   <= sh_y_next;
        sq_x_reg   <= sq_x_next;
        sq_y_reg   <= sq_y_next;
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        dsh_reg    <= dsh_next;
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        div_x_reg  <= div_x_next;
        div_y_reg  <= div_y_next;
    end

    // root == bound scales by one, same as passing the target through
    assign limited = root_reg > bound;
    assign qx      = MAG_W'(div_x_reg[Q_W-1:0]);
    assign qy      = MAG_W'(div_y_reg[Q_W-1:0]);
    assign step_x  = neg_x_reg ? -qx : qx;
    assign step_y  = neg_y_reg ? -qy : qy;

endmodule

`default_nettype wire

// ===== sv/velocity_command_slew_limiter.sv =====
// velocity command slew limiter, top level: handshakes, sequencer, yaw clamp
// depends on vcsl_pkg, vcsl_step_bound, vcsl_planar
`timescale 1ns / 1ps
`default_nettype none

// Takes one velocity command beat (vx, vy, height, yaw rate, Q8.16) with a
// Q32.16 timestamp and returns one ramped command beat. The first beat after
// reset, or a beat whose time is earlier than the previous one, loads the
// targets directly; a beat with the same time repeats the held ramp. Otherwise
// the (vx, vy) change is shortened to max_linear_accel * dt along its own
// direction, the yaw-rate change is clamped to +-max_angular_accel * dt and
// height follows the target; a limit of zero lets that part follow the target.
// One beat is in flight at a time. A ramped beat runs three bit-serial
// phases: the step-bound multiply with delta squaring, the square root (one
// digit pair per cycle) alongside the scaling products, and restoring
// division (one quotient bit per cycle). A zero linear limit skips the root
// and division, and an uncut planar change skips the division; a seeding or
// held beat goes straight to the result. A finished result waits in the
// output register, and the next command beat is accepted while it waits.
// Limits are written through the cfg port (index 0 linear, 1 angular, others
// ignored) and must only change while the block is idle.

module velocity_command_slew_limiter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // limit register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vcsl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vcsl_pkg::VEL_W-1:0]           cfg_data,
    // command beats
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [vcsl_pkg::VEL_W-1:0]    s_cmd_vx,
    input  logic signed [vcsl_pkg::VEL_W-1:0]    s_cmd_vy,
    input  logic signed [vcsl_pkg::VEL_W-1:0]    s_cmd_height,
    input  logic signed [vcsl_pkg::VEL_W-1:0]    s_cmd_yaw_rate,
    input  logic [vcsl_pkg::TIME_W-1:0]          s_now_time,
    // ramped beats
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [vcsl_pkg::VEL_W-1:0]    m_out_vx,
    output logic signed [vcsl_pkg::VEL_W-1:0]    m_out_vy,
    output logic signed [vcsl_pkg::VEL_W-1:0]    m_out_height,
    output logic signed [vcsl_pkg::VEL_W-1:0]    m_out_yaw_rate
);

    localparam int VW = vcsl_pkg::VEL_W;
    localparam int DW = vcsl_pkg::DELTA_W;
    localparam int SW = vcsl_pkg::STEP_W;
    localparam int CW = vcsl_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUND,
        ST_ROOT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_SEED,
        MODE_HOLD,
        MODE_RAMP
    } mode_t;

    // control state
    state_t                        state_reg, state_next;
    mode_t                         mode_reg, mode_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          started_reg, started_next;
    logic [vcsl_pkg::TIME_W-1:0]   last_time_reg, last_time_next;
    logic [VW-1:0]                 lin_lim_reg, lin_lim_next;
    logic [VW-1:0]                 ang_lim_reg, ang_lim_next;
    logic signed [VW-1:0]          ramp_vx_reg, ramp_vx_next;
    logic signed [VW-1:0]          ramp_vy_reg, ramp_vy_next;
    logic signed [VW-1:0]          ramp_h_reg, ramp_h_next;
    logic signed [VW-1:0]          ramp_w_reg, ramp_w_next;

    // captured beat
    logic signed [VW-1:0]          tx_reg, ty_reg, th_reg, tw_reg;
    logic [vcsl_pkg::TIME_W-1:0]   dt_reg;

    logic                          accept, cfg_wr, done_fire;
    logic                          lin_on, ang_on;
    logic [vcsl_pkg::TIME_W:0]     tdiff;
    logic signed [DW-1:0]          dx_in, dy_in;
    logic [SW-1:0]                 lin_bound, ang_bound;
    logic                          plan_limited;
    logic signed [DW-1:0]          plan_sx, plan_sy;
    logic signed [DW-1:0]          sum_x, sum_y;
    logic signed [SW:0]            dw_ext, bnd_pos, bnd_neg, dw_cl, yaw_sum;
    logic signed [VW-1:0]          ramp_x_new, ramp_y_new, ramp_w_new;
    logic                          bound_step;
    vcsl_pkg::plan_ctrl_t          plan_ctrl;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign done_fire = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign lin_on    = (lin_lim_reg != '0);
    assign ang_on    = (ang_lim_reg != '0);

    // borrow out flags time running backwards
    assign tdiff = {1'b0, s_now_time} - {1'b0, last_time_reg};

    // deltas against the current ramp, taken as the beat is accepted
    assign dx_in = {s_cmd_vx[VW-1], s_cmd_vx} - {ramp_vx_reg[VW-1], ramp_vx_reg};
    assign dy_in = {s_cmd_vy[VW-1], s_cmd_vy} - {ramp_vy_reg[VW-1], ramp_vy_reg};

    // sequencer strobes
    assign bound_step          = (state_reg == ST_BOUND);
    assign plan_ctrl.load      = accept;
    assign plan_ctrl.sq_step   = (state_reg == ST_BOUND);
    assign plan_ctrl.root_load = (state_reg == ST_ROOT) && (cnt_reg == '0);
    assign plan_ctrl.root_step = (state_reg == ST_ROOT) && (cnt_reg != '0);
    assign plan_ctrl.div_load  = (state_reg == ST_DIV) && (cnt_reg == '0) && plan_limited;
    assign plan_ctrl.div_step  = (state_reg == ST_DIV) && (cnt_reg != '0);

    vcsl_step_bound u_lin_bound (
        .aclk  (aclk),
        .load  (accept),
        .step  (bound_step),
        .limit (lin_lim_reg),
        .dt    (dt_reg),
        .bound (lin_bound)
    );

    vcsl_step_bound u_ang_bound (
        .aclk  (aclk),
        .load  (accept),
        .step  (bound_step),
        .limit (ang_lim_reg),
        .dt    (dt_reg),
        .bound (ang_bound)
    );

    vcsl_planar u_planar (
        .aclk    (aclk),
        .ctrl    (plan_ctrl),
        .dx      (dx_in),
        .dy      (dy_in),
        .bound   (lin_bound),
        .limited (plan_limited),
        .step_x  (plan_sx),
        .step_y  (plan_sy)
    );

    // new ramp values for a timed beat
    always_comb begin
        sum_x   = {ramp_vx_reg[VW-1], ramp_vx_reg} + plan_sx;
        sum_y   = {ramp_vy_reg[VW-1], ramp_vy_reg} + plan_sy;
        dw_ext  = (SW+1)'({tw_reg[VW-1], tw_reg} - {ramp_w_reg[VW-1], ramp_w_reg});
        dw_ext  = {{(SW+1-DW){dw_ext[DW-1]}}, dw_ext[DW-1:0]};
        bnd_pos = {1'b0, ang_bound};
        bnd_neg = -bnd_pos;
        if (dw_ext > bnd_pos) begin
            dw_cl = bnd_pos;
        end else if (dw_ext < bnd_neg) begin
            dw_cl = bnd_neg;
        end else begin
            dw_cl = dw_ext;
        end
        yaw_sum    = {{(SW+1-VW){ramp_w_reg[VW-1]}}, ramp_w_reg} + dw_cl;
        ramp_x_new = (lin_on && plan_limited) ? sum_x[VW-1:0] : tx_reg;
        ramp_y_new = (lin_on && plan_limited) ? sum_y[VW-1:0] : ty_reg;
        ramp_w_new = ang_on ? yaw_sum[VW-1:0] : tw_reg;
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        started_next   = started_reg;
        last_time_next = last_time_reg;
        lin_lim_next   = lin_lim_reg;
        ang_lim_next   = ang_lim_reg;
        ramp_vx_next   = ramp_vx_reg;
        ramp_vy_next   = ramp_vy_reg;
        ramp_h_next    = ramp_h_reg;
        ramp_w_next    = ramp_w_reg;

        if (cfg_wr && cfg_index == vcsl_pkg::CFG_LIN_ACCEL) begin
            lin_lim_next = cfg_data;
        end
        if (cfg_wr && cfg_index == vcsl_pkg::CFG_ANG_ACCEL) begin
            ang_lim_next = cfg_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next       = '0;
                    started_next   = 1'b1;
                    last_time_next = s_now_time;
                    if (!started_reg || tdiff[vcsl_pkg::TIME_W]) begin
                        mode_next  = MODE_SEED;
                        state_next = ST_DONE;
                    end else if (tdiff[vcsl_pkg::TIME_W-1:0] == '0) begin
                        mode_next  = MODE_HOLD;
                        state_next = ST_DONE;
                    end else begin
                        mode_next  = MODE_RAMP;
                        state_next = ST_BOUND;
                    end
                end
            end
            ST_BOUND: begin
                if (cnt_reg == CW'(vcsl_pkg::BOUND_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = lin_on ? ST_ROOT : ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROOT: begin
                // a load step, then one digit pair per cycle
                if (cnt_reg == CW'(vcsl_pkg::ROOT_STEPS)) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV: begin
                if (cnt_reg == '0 && !plan_limited) begin
                    state_next = ST_DONE;
                end else if (cnt_reg == CW'(vcsl_pkg::DIV_STEPS)) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                // ramp registers double as the output register
                if (done_fire) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    case (mode_reg)
                        MODE_SEED: begin
                            ramp_vx_next = tx_reg;
                            ramp_vy_next = ty_reg;
                            ramp_h_next  = th_reg;
                            ramp_w_next  = tw_reg;
                        end
                        MODE_RAMP: begin
                            ramp_vx_next = ramp_x_new;
                            ramp_vy_next = ramp_y_new;
                            ramp_h_next  = th_reg;
                            ramp_w_next  = ramp_w_new;
                        end
                        default: begin
                            // no time passed: repeat the held ramp
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_SEED;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            started_reg   <= 1'b0;
            last_time_reg <= '0;
            lin_lim_reg   <= '0;
            ang_lim_reg   <= '0;
            ramp_vx_reg   <= '0;
            ramp_vy_reg   <= '0;
            ramp_h_reg    <= '0;
            ramp_w_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
            started_reg   <= started_next;
            last_time_reg <= last_time_next;
            lin_lim_reg   <= lin_lim_next;
            ang_lim_reg   <= ang_lim_next;
            ramp_vx_reg   <= ramp_vx_next;
            ramp_vy_reg   <= ramp_vy_next;
            ramp_h_reg    <= ramp_h_next;
            ramp_w_reg    <= ramp_w_next;
        end
    end

    // captured beat, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            tx_reg <= s_cmd_vx;
            ty_reg <= s_cmd_vy;
            th_reg <= s_cmd_height;
            tw_reg <= s_cmd_yaw_rate;
            dt_reg <= tdiff[vcsl_pkg::TIME_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_vx       = ramp_vx_reg;
    assign m_out_vy       = ramp_vy_reg;
    assign m_out_height   = ramp_h_reg;
    assign m_out_yaw_rate = ramp_w_reg;

    // one beat in flight: acceptance closes the input side
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command accepted while a beat is still in flight");

    // divide phase only runs for a cut planar change
    a_div_only_limited: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg != '0) |-> (plan_limited && lin_on))
        else $error("divide running without an active planar limit");

    // every beat moves the time reference
    a_time_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (last_time_reg == $past(s_now_time)))
        else $error("time reference not taken from accepted beat");

    // a finished ramp waits while the output register is still full
    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=>
        (state_reg == ST_DONE && $stable(ramp_vx_reg) && $stable(ramp_w_reg)))
        else $error("ramp updated over an untaken result");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the velocity command slew limiter
// depends on vcsl_pkg and velocity_command_slew_limiter; predicts every ramp beat in place
`timescale 1ns / 1ps

module testbench;
    import vcsl_pkg::*;

    // q8.16 and q32.16 corner values
    localparam logic signed [VEL_W-1:0] VEL_MAX  = 24'sh7FFFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN  = 24'sh800000;
    localparam logic signed [VEL_W-1:0] ONE_UNIT = 24'sh010000;
    localparam logic [TIME_W-1:0]       ONE_SEC  = 48'h0000_0001_0000;
    localparam logic [TIME_W-1:0]       TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0]             STEP_CAP = (64'd1 << STEP_W) - 64'd1;

    // register indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_STRAY_LO = CFG_ANG_ACCEL + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAY_HI = '1;

    localparam int STALL_LIMIT  = 4000;   // cycles without any handshake
    localparam int SETTLE_TICKS = 100;    // extra wait after the final drain
    localparam int RANDOM_BEATS = 160;    // per random phase, nine phases

    typedef struct packed {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] height;
        logic signed [VEL_W-1:0] yaw_rate;
        logic [TIME_W-1:0]       now_time;
    } cmd_beat_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] height;
        logic signed [VEL_W-1:0] yaw_rate;
    } ramp_beat_t;

    // dut connections, all driven to known values from time zero
    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    cfg_valid      = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index      = '0;
    logic [VEL_W-1:0]        cfg_data       = '0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic signed [VEL_W-1:0] s_cmd_vx       = '0;
    logic signed [VEL_W-1:0] s_cmd_vy       = '0;
    logic signed [VEL_W-1:0] s_cmd_height   = '0;
    logic signed [VEL_W-1:0] s_cmd_yaw_rate = '0;
    logic [TIME_W-1:0]       s_now_time     = '0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic signed [VEL_W-1:0] m_out_vx;
    logic signed [VEL_W-1:0] m_out_vy;
    logic signed [VEL_W-1:0] m_out_height;
    logic signed [VEL_W-1:0] m_out_yaw_rate;

    // predicted block state: held ramp, last timestamp, seeded flag, limits
    logic signed [VEL_W-1:0] held_vx       = '0;
    logic signed [VEL_W-1:0] held_vy       = '0;
    logic signed [VEL_W-1:0] held_height   = '0;
    logic signed [VEL_W-1:0] held_yaw_rate = '0;
    logic [TIME_W-1:0]       prev_stamp    = '0;
    logic                    ramp_seeded   = 1'b0;
    logic [VEL_W-1:0]        lin_limit     = '0;
    logic [VEL_W-1:0]        ang_limit     = '0;

    cmd_beat_t  last_target   = '0;
    ramp_beat_t pending_ramps[$];

    int send_idle_pct  = 28;
    int recv_idle_pct  = 56;
    int beats_sent     = 0;
    int regs_written   = 0;
    int ramps_checked  = 0;
    int mismatch_count = 0;

    velocity_command_slew_limiter u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd_vx       (s_cmd_vx),
        .s_cmd_vy       (s_cmd_vy),
        .s_cmd_height   (s_cmd_height),
        .s_cmd_yaw_rate (s_cmd_yaw_rate),
        .s_now_time     (s_now_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_vx       (m_out_vx),
        .m_out_vy       (m_out_vy),
        .m_out_height   (m_out_height),
        .m_out_yaw_rate (m_out_yaw_rate)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // ramp prediction
    // ---------------------------------------------------------------------

    // floor(limit * dt / 2^16), exact over the full 48-bit dt, then capped
    function automatic logic [63:0] step_size(input logic [VEL_W-1:0] limit,
                                              input logic [TIME_W-1:0] dt);
        logic [63:0] whole;
        logic [63:0] part;
        whole = 64'(limit) * 64'(dt[TIME_W-1:FRAC_W]);
        part  = (64'(limit) * 64'(dt[FRAC_W-1:0])) >> FRAC_W;
        whole = whole + part;
        return (whole > STEP_CAP) ? STEP_CAP : whole;
    endfunction

    // bitwise integer square root, floor
    function automatic logic [63:0] root_floor(input logic [63:0] val);
        logic [63:0] root;
        logic [63:0] bitpos;
        root   = '0;
        bitpos = 64'd1 << 62;
        while (bitpos > val) bitpos = bitpos >> 2;
        while (bitpos != 0) begin
            if (val >= root + bitpos) begin
                val  = val - (root + bitpos);
                root = (root >> 1) + bitpos;
            end else begin
                root = root >> 1;
            end
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    // delta * num / den, truncated toward zero
    function automatic longint scaled_delta(input longint delta, input logic [63:0] num,
                                            input logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] quo;
        mag = (delta < 0) ? 64'(-delta) : 64'(delta);
        quo = (mag * num) / den;
        return (delta < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // advance the predicted state by one command beat and return the ramp it yields
    function automatic ramp_beat_t apply_slew_limit(input cmd_beat_t cmd);
        logic [TIME_W-1:0] dt;
        logic [63:0] lin_step;
        logic [63:0] dist_sq;
        logic [63:0] dist_len;
        longint      dx;
        longint      dy;
        longint      dw;
        longint      ang_step;
        longint      next_vx;
        longint      next_vy;
        longint      next_yaw;
        ramp_beat_t  ramp;
        if (!ramp_seeded || cmd.now_time < prev_stamp) begin
            // first beat or time ran backwards: jump to the target
            held_vx       = cmd.vx;
            held_vy       = cmd.vy;
            held_height   = cmd.height;
            held_yaw_rate = cmd.yaw_rate;
            ramp_seeded   = 1'b1;
        end else if (cmd.now_time != prev_stamp) begin
            dt       = cmd.now_time - prev_stamp;
            next_vx  = longint'(cmd.vx);
            next_vy  = longint'(cmd.vy);
            next_yaw = longint'(cmd.yaw_rate);
            if (lin_limit != 0) begin
                lin_step = step_size(lin_limit, dt);
                dx       = longint'(cmd.vx) - longint'(held_vx);
                dy       = longint'(cmd.vy) - longint'(held_vy);
                dist_sq  = dx * dx + dy * dy;
                if (dist_sq > lin_step * lin_step) begin
                    dist_len = root_floor(dist_sq);
                    next_vx  = longint'(held_vx) + scaled_delta(dx, lin_step, dist_len);
                    next_vy  = longint'(held_vy) + scaled_delta(dy, lin_step, dist_len);
                end
            end
            if (ang_limit != 0) begin
                ang_step = longint'(step_size(ang_limit, dt));
                dw       = longint'(cmd.yaw_rate) - longint'(held_yaw_rate);
                if (dw > ang_step) dw = ang_step;
                if (dw < -ang_step) dw = -ang_step;
                next_yaw = longint'(held_yaw_rate) + dw;
            end
            held_vx       = next_vx[VEL_W-1:0];
            held_vy       = next_vy[VEL_W-1:0];
            held_height   = cmd.height;
            held_yaw_rate = next_yaw[VEL_W-1:0];
        end
        // equal timestamps fall through: everything held, height included
        prev_stamp    = cmd.now_time;
        ramp.vx       = held_vx;
        ramp.vy       = held_vy;
        ramp.height   = held_height;
        ramp.yaw_rate = held_yaw_rate;
        return ramp;
    endfunction

    // ---------------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------------

    // receiver back-pressure, rerolled every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one command beat; valid stays up with a fixed payload until accepted
    task automatic send_cmd(input cmd_beat_t cmd);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_cmd_vx       <= cmd.vx;
        s_cmd_vy       <= cmd.vy;
        s_cmd_height   <= cmd.height;
        s_cmd_yaw_rate <= cmd.yaw_rate;
        s_now_time     <= cmd.now_time;
        do @(posedge aclk); while (!s_ready);
        pending_ramps.push_back(apply_slew_limit(cmd));
        last_target = cmd;
        beats_sent++;
    endtask

    // register write; cfg_valid is left high so back-to-back writes need one assignment
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VEL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_LIN_ACCEL) lin_limit = val;
        else if (idx == CFG_ANG_ACCEL) ang_limit = val;
        regs_written++;
    endtask

    task automatic set_limits(input logic [VEL_W-1:0] lin, input logic [VEL_W-1:0] ang,
                              input bit with_stray);
        if (with_stray)
            write_reg(CFG_IDX_W'($urandom_range(CFG_STRAY_LO, CFG_STRAY_HI)),
                      VEL_W'($urandom()));
        write_reg(CFG_LIN_ACCEL, lin);
        write_reg(CFG_ANG_ACCEL, ang);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every predicted ramp beat has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_ramps.size() != 0) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    function automatic cmd_beat_t make_cmd(input logic signed [VEL_W-1:0] vx,
                                           input logic signed [VEL_W-1:0] vy,
                                           input logic signed [VEL_W-1:0] height,
                                           input logic signed [VEL_W-1:0] yaw_rate,
                                           input logic [TIME_W-1:0] stamp);
        cmd_beat_t cmd;
        cmd.vx       = vx;
        cmd.vy       = vy;
        cmd.height   = height;
        cmd.yaw_rate = yaw_rate;
        cmd.now_time = stamp;
        return cmd;
    endfunction

    // value within a random power-of-two distance of base, clamped to q8.16 range
    function automatic logic signed [VEL_W-1:0] near_value(input logic signed [VEL_W-1:0] base);
        longint reach;
        longint val;
        reach = longint'(1) << $urandom_range(0, 18);
        val   = longint'(base) + longint'($urandom_range(0, 2 * reach)) - reach;
        if (val > longint'(VEL_MAX)) val = longint'(VEL_MAX);
        if (val < longint'(VEL_MIN)) val = longint'(VEL_MIN);
        return val[VEL_W-1:0];
    endfunction

    function automatic logic signed [VEL_W-1:0] rail_value();
        return $urandom_range(1) ? VEL_MAX : VEL_MIN;
    endfunction

    // limits spread over every magnitude, not just the top octave
    function automatic logic [VEL_W-1:0] random_limit();
        return VEL_W'($urandom()) >> $urandom_range(0, VEL_W - 1);
    endfunction

    // mostly a running command stream with short forward steps, plus holds,
    // time running backwards, long gaps and raw noise
    function automatic cmd_beat_t random_cmd();
        cmd_beat_t   cmd;
        logic [63:0] raw;
        int          pick;
        raw  = {$urandom(), $urandom()};
        pick = $urandom_range(99);
        if (pick < 55)
            cmd.now_time = prev_stamp + TIME_W'($urandom_range(1, 16'h4000));
        else if (pick < 65)
            cmd.now_time = prev_stamp + TIME_W'($urandom_range(1, 16));
        else if (pick < 75)
            cmd.now_time = prev_stamp;
        else if (pick < 82)
            cmd.now_time = prev_stamp + TIME_W'($urandom());
        else if (pick < 90)
            cmd.now_time = (prev_stamp == 0) ? '0 : TIME_W'(raw % 64'(prev_stamp));
        else
            cmd.now_time = raw[TIME_W-1:0];

        pick = $urandom_range(99);
        if (pick < 45) begin
            cmd.vx       = VEL_W'($urandom());
            cmd.vy       = VEL_W'($urandom());
            cmd.yaw_rate = VEL_W'($urandom());
        end else if (pick < 75) begin
            cmd.vx       = near_value(held_vx);
            cmd.vy       = near_value(held_vy);
            cmd.yaw_rate = near_value(held_yaw_rate);
        end else if (pick < 85) begin
            cmd.vx       = rail_value();
            cmd.vy       = rail_value();
            cmd.yaw_rate = rail_value();
        end else begin
            // same target again so the ramp keeps closing in on it
            cmd.vx       = last_target.vx;
            cmd.vy       = last_target.vy;
            cmd.yaw_rate = last_target.yaw_rate;
        end
        cmd.height = ($urandom_range(9) == 0) ? rail_value() : VEL_W'($urandom());
        return cmd;
    endfunction

    // ---------------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------------

    task automatic check_field(input string label, input logic signed [VEL_W-1:0] want,
                               input logic signed [VEL_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s expected %0d got %0d", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin : ramp_check
        ramp_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_ramps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: ramp beat with nothing outstanding", $time);
            end else begin
                want = pending_ramps.pop_front();
                ramps_checked++;
                check_field("out_vx", want.vx, m_out_vx);
                check_field("out_vy", want.vy, m_out_vy);
                check_field("out_height", want.height, m_out_height);
                check_field("out_yaw_rate", want.yaw_rate, m_out_yaw_rate);
            end
        end
    end

    // ends the run if no channel moves a beat for too long
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // limits still zero from reset: seeding at time zero, hold, follow, backwards
    task automatic test_seed_and_hold();
        send_cmd(make_cmd(VEL_MAX, VEL_MIN, VEL_MAX, VEL_MIN, '0));
        send_cmd(make_cmd('0, '0, '0, '0, '0));
        send_cmd(make_cmd(VEL_MIN, VEL_MAX, VEL_MIN, VEL_MAX, ONE_SEC));
        send_cmd(make_cmd(24'sd123, -24'sd456, 24'sd789, -24'sd1011, ONE_SEC >> 1));
        send_cmd(make_cmd(VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, TIME_MAX));
    endtask

    // 1.0/s planar and 2.0/s yaw: cut vectors both ways, uncut small change,
    // one-lsb dt, and a gap long enough to saturate the step bound
    task automatic test_limited_ramp();
        drain_results();
        set_limits(ONE_UNIT, ONE_UNIT <<< 1, 1'b0);
        send_cmd(make_cmd('0, '0, '0, '0, ONE_SEC));
        send_cmd(make_cmd(24'sd3 * ONE_UNIT, 24'sd4 * ONE_UNIT, ONE_UNIT,
                          24'sd5 * ONE_UNIT, 2 * ONE_SEC));
        send_cmd(make_cmd(24'sd3 * ONE_UNIT, 24'sd4 * ONE_UNIT, ONE_UNIT,
                          24'sd5 * ONE_UNIT, 2 * ONE_SEC + (ONE_SEC >> 1)));
        send_cmd(make_cmd(-24'sd3 * ONE_UNIT, -24'sd4 * ONE_UNIT, -ONE_UNIT,
                          -24'sd5 * ONE_UNIT, 4 * ONE_SEC));
        send_cmd(make_cmd(held_vx + 24'sd256, held_vy - 24'sd128, VEL_MIN,
                          held_yaw_rate + 24'sd64, 5 * ONE_SEC));
        send_cmd(make_cmd(VEL_MAX, VEL_MIN, VEL_MAX, VEL_MIN, 5 * ONE_SEC + 1));
        send_cmd(make_cmd(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, 48'hFFFF_FFFF_0000));
    endtask

    // full-scale limits: largest planar swing in one lsb of time, then the
    // largest dt of all
    task automatic test_saturated_bound();
        drain_results();
        set_limits('1, '1, 1'b0);
        send_cmd(make_cmd(VEL_MAX, VEL_MAX, '0, VEL_MAX, 48'd1));
        send_cmd(make_cmd(VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, 48'd2));
        send_cmd(make_cmd('0, '0, VEL_MAX, '0, TIME_MAX));
    endtask

    // writes to unused indexes must leave both limits untouched
    task automatic test_register_map();
        drain_results();
        write_reg(CFG_STRAY_LO, VEL_W'(1));
        write_reg(CFG_STRAY_HI, '0);
        cfg_valid <= 1'b0;
        send_cmd(make_cmd('0, '0, '0, '0, '0));
        send_cmd(make_cmd(VEL_MAX, VEL_MIN, VEL_MAX, VEL_MAX, 48'd1));
    endtask

    task automatic test_random_ramp(input logic [VEL_W-1:0] lin, input logic [VEL_W-1:0] ang);
        drain_results();
        set_limits(lin, ang, 1'b1);
        repeat (RANDOM_BEATS) send_cmd(random_cmd());
    endtask

    initial begin
        // reset held low from time zero, then released on an edge
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 28;
        recv_idle_pct = 56;
        test_seed_and_hold();
        test_limited_ramp();
        test_saturated_bound();
        test_register_map();
        test_random_ramp(24'h100000, 24'h080000);
        test_random_ramp('0, 24'h200000);
        test_random_ramp(24'h040000, '0);

        // roles swapped: bursty sender, mostly ready receiver
        send_idle_pct = 56;
        recv_idle_pct = 28;
        test_random_ramp('1, '1);
        test_random_ramp(VEL_W'(1), VEL_W'(1));
        test_random_ramp(random_limit(), random_limit());

        // both sides at full rate
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ramp(24'h800000, ONE_UNIT);
        test_random_ramp(random_limit(), random_limit());
        test_random_ramp('0, '0);

        drain_results();
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (pending_ramps.size() != 0) begin
            mismatch_count += pending_ramps.size();
            $display("%0d ramp beats never arrived", pending_ramps.size());
        end

        $display("sent %0d command beats over %0d limit writes, %0d ramp beats checked",
                 beats_sent, regs_written, ramps_checked);
        $display("limits swept zero to full scale under three idle mixes, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/vcsl_pkg.sv
sv/vcsl_step_bound.sv
sv/vcsl_planar.sv
sv/velocity_command_slew_limiter.sv
verif/testbench.sv
